// ===== hw/rtl/sorted_priority_queue_defines.svh =====
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SPQ_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Types and constants shared by the sorted priority queue modules.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 10;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  localparam logic [PRIO_W-1:0] LOWEST_PRIO = 10'd999;

  // Request opcodes. Bit 1 set means dequeue, so the spare code dequeues too.
  localparam logic [OP_W-1:0] OP_ENQ_PLAIN = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ_PRIO  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQ       = 2'd2;
  localparam logic [OP_W-1:0] OP_DEQ_ALT   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } spq_entry_t;

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    logic       ins;
    logic       deq;
    spq_entry_t item;
  } spq_cmd_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t  cmd_i,
  input  logic               occ_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic               left_gt_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic               gt_o
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // The new item belongs at or before this cell when the cell is free or
  // holds a strictly worse priority; equal priorities stay ahead (stable).
  assign gt_o    = !occ_i || (entry_r.prio > cmd_i.item.prio);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.deq) begin
      entry_nxt = right_i;
    end else if (cmd_i.ins && gt_o) begin
      if (left_gt_i) begin
        entry_nxt = left_i;
      end else begin
        entry_nxt = cmd_i.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the bounded, stable sorted priority queue built as a chain of cells.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload (tdata, lowest bit first)
//  in_*      slave      op[1:0], value[33:2], priority_req[43:34], zero pad to 48
//  out_*     master     status[1:0], out_value[33:2], now_empty[34], zero pad to 40
//
//  All cells compare their stored priority with a request in parallel
//  and shift by one place in the same edge, so the chain of DEPTH cells
//  sets the cost, not a loop over entries.
//  A request is taken each cycle while the output register is free or drained.
//  Reset (rst_n low, synchronous) clears the fill count and the output valid;
//  cell contents are left as they are and are never read until written.
//  A stalled result holds in the output register and stalls the input side.

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[1:0], value[33:2], priority_req[43:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], out_value[33:2], now_empty[34]
);
  import spq_pkg::*;

`include "sorted_priority_queue_defines.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Unpacked request fields.
  logic        [OP_W-1:0]    req_op;
  logic signed [VALUE_W-1:0] req_value;
  logic        [PRIO_W-1:0]  req_prio;
  logic        [PRIO_W-1:0]  eff_prio;
  logic                      in_fire;
  logic                      is_deq;
  logic                      is_full;
  logic                      is_empty;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  spq_cmd_t   cmd;
  spq_entry_t cell_entry [DEPTH];
  logic       cell_gt    [DEPTH];
  logic       cell_occ   [DEPTH];

  // Result register.
  logic                      out_valid_r;
  logic        [STAT_W-1:0]  out_status_r;
  logic        [STAT_W-1:0]  out_status_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic signed [VALUE_W-1:0] out_value_nxt;
  logic                      out_empty_r;

  assign req_op    = in_tdata[1:0];
  assign req_value = in_tdata[33:2];
  assign req_prio  = in_tdata[43:34];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_full   = (cnt_r == FULL_CNT);
  assign is_empty  = (cnt_r == '0);

  // Decode the opcode and pick the priority the new entry will carry.
  always_comb begin
    is_deq   = 1'b0;
    eff_prio = LOWEST_PRIO;
    case (req_op) inside
      OP_DEQ, OP_DEQ_ALT: is_deq = 1'b1;
      OP_ENQ_PRIO: begin
        eff_prio = (req_prio > LOWEST_PRIO) ? LOWEST_PRIO : req_prio;
      end
      default: eff_prio = LOWEST_PRIO;
    endcase
  end

  always_comb begin
    cmd.ins        = in_fire && !is_deq && !is_full;
    cmd.deq        = in_fire && is_deq && !is_empty;
    cmd.item.value = req_value;
    cmd.item.prio  = eff_prio;
  end

  // The chain: cell 0 is the front of the queue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_e;
    logic       left_gt;
    spq_entry_t right_e;

    assign cell_occ[i] = (CNT_W'(i) < cnt_r);

    if (i == 0) begin : g_head
      assign left_e  = cmd.item;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = cell_entry[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd_i     (cmd),
      .occ_i     (cell_occ[i]),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cell_entry[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Fill count and the status of this request.
  always_comb begin
    cnt_nxt        = cnt_r;
    out_status_nxt = ST_ENQUEUED;
    out_value_nxt  = '0;
    if (is_deq) begin
      if (is_empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_status_nxt = ST_DEQUEUED;
        out_value_nxt  = cell_entry[0].value;
        cnt_nxt        = cnt_r - CNT_W'(1);
      end
    end else if (is_full) begin
      out_status_nxt = ST_FULL;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_empty_r, out_value_r, out_status_r};

  // The fill count never runs past the number of cells.
  `SPQ_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= FULL_CNT, "fill count exceeds depth")

  // A dequeue from a non-empty queue removes exactly one entry.
  `SPQ_ASSERT_NEXT(a_deq_count, clk, rst_n, in_fire && is_deq && !is_empty, cnt_r == $past(cnt_r) - CNT_W'(1), "dequeue did not drop one entry")

  // Every accepted request leaves a result waiting in the next cycle.
  `SPQ_ASSERT_NEXT(a_result_follows, clk, rst_n, in_fire, out_valid_r, "accepted request produced no result")

  // An empty report always says the queue is empty afterwards.
  `SPQ_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid_r && (out_status_r == ST_EMPTY), out_empty_r, "empty status without empty flag")

endmodule
